[design/b64d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;
    localparam logic [1:0] PAD_TWO  = 2'd2;
    localparam logic [1:0] PAD_WAIT = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LENGTH = 2'd1;
    localparam logic [1:0] ST_SYMBOL = 2'd2;

    typedef struct packed {
        logic       legal;
        logic       pad;
        logic [5:0] value;
    } sextet_t;

    // up to three result items produced by one input item
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            byte_valid;
        logic            done;
        logic [1:0]      status;
    } bundle_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.legal = 1'b1;
        s.pad   = 1'b0;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.value = 6'd63;
        end else if (c == 8'h3D) begin
            s.pad = 1'b1;
        end else begin
            s.legal = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[design/b64d_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64d_core (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_valid,
    input  wire                 cfg_data,
    input  wire                 take,
    input  wire  [7:0]          symbol,
    input  wire                 has_symbol,
    input  wire                 end_of_text,
    output b64d_pkg::bundle_t   bundle,
    output logic                bundle_load
);

    logic [17:0] hold_reg, hold_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pad_reg, pad_next;
    logic        err_reg, err_next;
    logic        skip_reg;

    b64d_pkg::sextet_t sx;
    logic        ws;
    logic        present;
    logic [17:0] hold_s;
    logic [1:0]  pos_s;
    logic [1:0]  pad_s;
    logic        err_s;
    logic        quad_out;
    logic [1:0]  status_s;
    logic        load;

    always_comb begin
        sx = b64d_pkg::sextet_of(symbol);
        ws = skip_reg && (symbol == 8'h20 || (symbol >= 8'h09 && symbol <= 8'h0D));
        present = has_symbol && !ws;

        hold_s   = hold_reg;
        pos_s    = pos_reg;
        pad_s    = pad_reg;
        err_s    = err_reg;
        quad_out = 1'b0;

        if (present) begin
            if (pos_reg == 2'd0 && pad_reg != b64d_pkg::PAD_NONE) begin
                err_s = 1'b1;
            end else if (!sx.legal) begin
                err_s = 1'b1;
            end else if (pos_reg < 2'd2) begin
                if (sx.pad) begin
                    err_s = 1'b1;
                end else begin
                    hold_s = {hold_reg[11:0], sx.value};
                end
            end else if (pos_reg == 2'd2) begin
                if (sx.pad) begin
                    pad_s  = b64d_pkg::PAD_WAIT;
                    hold_s = {hold_reg[11:0], 6'd0};
                end else begin
                    hold_s = {hold_reg[11:0], sx.value};
                end
            end else if (pad_reg == b64d_pkg::PAD_WAIT) begin
                if (sx.pad) begin
                    pad_s = b64d_pkg::PAD_TWO;
                end else begin
                    err_s = 1'b1;
                end
            end else if (sx.pad) begin
                pad_s = b64d_pkg::PAD_ONE;
            end else if (!err_reg) begin
                quad_out = 1'b1;
            end
            pos_s = pos_reg + 2'd1;
        end

        if (pos_s != 2'd0) begin
            status_s = b64d_pkg::ST_LENGTH;
        end else if (err_s) begin
            status_s = b64d_pkg::ST_SYMBOL;
        end else begin
            status_s = b64d_pkg::ST_OK;
        end

        bundle.bytes[0]   = {hold_s[17:12], hold_s[11:10]};
        bundle.bytes[1]   = {hold_s[9:6], hold_s[5:2]};
        bundle.bytes[2]   = {hold_s[1:0], sx.value};
        bundle.last_idx   = 2'd2;
        bundle.byte_valid = 1'b1;
        bundle.done       = 1'b0;
        bundle.status     = b64d_pkg::ST_OK;
        load              = quad_out;

        if (end_of_text) begin
            load        = 1'b1;
            bundle.done = 1'b1;
            if (status_s != b64d_pkg::ST_OK) begin
                bundle.byte_valid = 1'b0;
                bundle.last_idx   = 2'd0;
                bundle.status     = status_s;
            end else if (quad_out) begin
                bundle.last_idx = 2'd2;
            end else if (pad_s == b64d_pkg::PAD_ONE) begin
                bundle.last_idx = 2'd1;
            end else if (pad_s == b64d_pkg::PAD_TWO) begin
                bundle.last_idx = 2'd0;
            end else begin
                bundle.byte_valid = 1'b0;
                bundle.last_idx   = 2'd0;
            end
        end

        if (!bundle.byte_valid) begin
            bundle.bytes = '0;
        end

        bundle_load = take && load;

        if (take && end_of_text) begin
            hold_next = '0;
            pos_next  = 2'd0;
            pad_next  = b64d_pkg::PAD_NONE;
            err_next  = 1'b0;
        end else if (take) begin
            hold_next = hold_s;
            pos_next  = pos_s;
            pad_next  = pad_s;
            err_next  = err_s;
        end else begin
            hold_next = hold_reg;
            pos_next  = pos_reg;
            pad_next  = pad_reg;
            err_next  = err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
            pos_reg  <= 2'd0;
            pad_reg  <= b64d_pkg::PAD_NONE;
            err_reg  <= 1'b0;
            skip_reg <= 1'b0;
        end else begin
            hold_reg <= hold_next;
            pos_reg  <= pos_next;
            pad_reg  <= pad_next;
            err_reg  <= err_next;
            if (cfg_valid) begin
                skip_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

[design/b64d_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64d_out (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  b64d_pkg::bundle_t   bundle_in,
    input  wire                 bundle_load,
    output logic                in_ready,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [7:0]          m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);

    b64d_pkg::bundle_t bundle_reg;
    logic              valid_reg;
    logic [1:0]        idx_reg;
    logic              last;
    logic [1:0]        status_out;

    assign last       = (idx_reg == bundle_reg.last_idx);
    assign in_ready   = !valid_reg || (m_tready && last);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = bundle_reg.bytes[idx_reg];
    assign m_tlast    = bundle_reg.done && last;
    assign status_out = m_tlast ? bundle_reg.status : b64d_pkg::ST_OK;
    assign m_tuser    = {status_out, bundle_reg.byte_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (bundle_load) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_tready) begin
            if (last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bundle_load) begin
            bundle_reg <= bundle_in;
        end
    end

    a_load_room: assert property (@(posedge aclk) disable iff (!aresetn)
        bundle_load |-> in_ready)
        else $error("bundle loaded while previous item still draining");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> idx_reg <= bundle_reg.last_idx)
        else $error("result index past end of bundle");

    a_status_final: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && bundle_reg.status != b64d_pkg::ST_OK |->
            bundle_reg.done && !bundle_reg.byte_valid && bundle_reg.last_idx == 2'd0)
        else $error("error status on a non-final or byte-carrying bundle");

    a_empty_final: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !bundle_reg.byte_valid |-> bundle_reg.done && m_tlast)
        else $error("empty result that does not close the message");

endmodule

`default_nettype wire

[design/base64_stream_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Base64 (standard alphabet, padded) decoder, one character per input item.
// A character is decoded and the message state updated in the cycle it is
// accepted; in the cycle after, its results sit in the output register. The
// output port delivers one byte per cycle while m_tready is high, so an item
// that completes a quad (three bytes) or closes a message on a single-'='
// quad (two bytes) holds s_tready low until its last byte is being taken.
// The end item (s_tlast) always closes with a result carrying m_tlast
// and the status; on a nonzero status the message's bytes must be dropped.
// Write skip_whitespace only while no item is in flight.
module base64_stream_decoder (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_data,       // skip_whitespace
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,        // [7:0] symbol
    input  wire  [0:0]  s_tuser,        // [0] has_symbol
    input  wire         s_tlast,        // end_of_text
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,        // [7:0] data_byte
    output logic [2:0]  m_tuser,        // [0] byte_valid, [2:1] status
    output logic        m_tlast         // message_done
);

    b64d_pkg::bundle_t bundle;
    logic              bundle_load;
    logic              in_ready;
    logic              take;

    assign cfg_ready = 1'b1;
    assign s_tready  = in_ready;
    assign take      = s_tvalid && in_ready;

    b64d_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .take        (take),
        .symbol      (s_tdata),
        .has_symbol  (s_tuser[0]),
        .end_of_text (s_tlast),
        .bundle      (bundle),
        .bundle_load (bundle_load)
    );

    b64d_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bundle_in   (bundle),
        .bundle_load (bundle_load),
        .in_ready    (in_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
